// File: design/hcj_pkg.sv
// Package for the HSV color jitter block: payload structs, register indexes,
// sector codes and the output clamp. No dependencies.
package hcj_pkg;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pixel_t;

	typedef struct packed {
		logic [12:0] red_out;
		logic [12:0] green_out;
		logic [12:0] blue_out;
	} result_t;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_HUE_SHIFT       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SATURATION_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE_GAIN   = 2'd2;

	localparam logic [2:0] SEC_0 = 3'd0;
	localparam logic [2:0] SEC_1 = 3'd1;
	localparam logic [2:0] SEC_2 = 3'd2;
	localparam logic [2:0] SEC_3 = 3'd3;
	localparam logic [2:0] SEC_4 = 3'd4;

	localparam logic [12:0] OUT_ONE = 13'd4096;

	// Drop four fraction bits of a Q.16 channel and clamp to 1.0.
	function automatic logic [12:0] to_out(input logic [23:0] x);
		logic [19:0] y;
		y = x[23:4];
		return (y > 20'(OUT_ONE)) ? OUT_ONE : y[12:0];
	endfunction

endpackage

// File: design/hsv_color_jitter_top.sv
// HSV color jitter top level: full pixel pipeline with two restoring dividers.
// Depends on hcj_pkg.
//
// Throughput: one pixel per clock; busy stays low and the pipeline never stalls.
// The receiver cannot stall: each result shows for one cycle with result_valid.
// Reset (arst_n low) clears all valid bits and loads hue_shift = 0, gains = 4096.
// The two dividers (hue and saturation) set the depth, one quotient bit per stage.
module hsv_color_jitter_top
	import hcj_pkg::*;
#(
	parameter int unsigned GAIN_FRAC_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pixel_t               pixel,
	output logic                 result_valid,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	// Quotient bits of the saturation divide; the hue divide runs the same count.
	localparam int unsigned QS  = 32 - GAIN_FRAC_BITS;
	localparam int unsigned SDW = QS + 8;   // saturation dividend width
	localparam int unsigned HDW = QS + 11;  // hue dividend width
	localparam int unsigned PW  = QS + 17;  // s * k product width
	localparam int unsigned L   = QS - 1;

	// ---------------------------------------------------------------- config
	logic signed [15:0] hue_shift_q;
	logic [15:0]        sat_gain_q;
	logic [15:0]        exp_gain_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_shift_q <= '0;
			sat_gain_q  <= 16'd4096;
			exp_gain_q  <= 16'd4096;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HUE_SHIFT:       hue_shift_q <= cfg_data;
				CFG_SATURATION_GAIN: sat_gain_q  <= cfg_data;
				CFG_EXPOSURE_GAIN:   exp_gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- stage 1
	// Find max/min, hue numerator, and the two gain products.
	logic [7:0]         r, g, b, mx, mn, delta;
	logic signed [11:0] h6_raw, d6;
	logic [10:0]        h6;

	always_comb begin
		r = pixel.red_in;
		g = pixel.green_in;
		b = pixel.blue_in;
		mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
		mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
		delta = mx - mn;
		d6 = $signed({4'b0, delta}) * 12'sd6;
		// Ties for max: red wins over green, green over blue.
		priority if (r == mx) begin
			h6_raw = $signed({4'b0, g}) - $signed({4'b0, b});
		end else if (g == mx) begin
			h6_raw = $signed({3'b0, delta, 1'b0}) + $signed({4'b0, b}) - $signed({4'b0, r});
		end else begin
			h6_raw = $signed({2'b0, delta, 2'b0}) + $signed({4'b0, r}) - $signed({4'b0, g});
		end
		if (h6_raw < 0) begin
			h6 = 11'(h6_raw + d6);
		end else begin
			h6 = 11'(h6_raw);
		end
	end

	logic        vld_s1;
	logic        grey_s1;
	logic [7:0]  mx_s1;
	logic [10:0] d6_s1;
	logic [10:0] h6_s1;
	logic [23:0] n_s1;
	logic [23:0] ds_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		grey_s1 <= (delta == 8'd0) || (sat_gain_q == 16'd0);
		mx_s1   <= mx;
		d6_s1   <= 11'(d6);
		h6_s1   <= h6;
		n_s1    <= 24'(mx) * 24'(exp_gain_q);
		ds_s1   <= 24'(delta) * 24'(sat_gain_q);
	end

	// ---------------------------------------------------------------- stage 2
	// Two restoring dividers side by side, one quotient bit per step.
	// Each dq register starts as the dividend's low bits and fills with quotient.
	logic [HDW-1:0] hd_init;
	logic [SDW-1:0] sd_init;
	logic [31:0]    xs;
	logic [63:0]    v_prod;

	always_comb begin
		hd_init = HDW'({h6_s1, 16'h0000});
		sd_init = SDW'(ds_s1) << (16 - GAIN_FRAC_BITS);
		xs      = 32'(n_s1) << (16 - GAIN_FRAC_BITS);
		// Divide by 255 with an exact 32-bit reciprocal.
		v_prod  = 64'(xs) * 64'(32'h8080_8081);
	end

	logic          vld_s2  [QS];
	logic          grey_s2 [QS];
	logic [23:0]   v16_s2  [QS];
	logic [7:0]    mx_s2   [QS];
	logic [10:0]   d6_s2   [QS];
	logic [QS-1:0] hdq_s2  [QS];
	logic [10:0]   hrem_s2 [QS];
	logic [QS-1:0] sdq_s2  [QS];
	logic [7:0]    srem_s2 [QS];

	for (genvar k = 0; k < QS; k++) begin : g_div
		logic          vld_i, grey_i;
		logic [23:0]   v16_i;
		logic [7:0]    mx_i, srem_i, srem_n;
		logic [10:0]   d6_i, hrem_i, hrem_n;
		logic [QS-1:0] hdq_i, sdq_i;
		logic [11:0]   htrial;
		logic [8:0]    strial;
		logic          hge, sge;

		if (k == 0) begin : g_first
			assign vld_i  = vld_s1;
			assign grey_i = grey_s1;
			assign v16_i  = v_prod[62:39];
			assign mx_i   = mx_s1;
			assign d6_i   = d6_s1;
			assign hdq_i  = hd_init[QS-1:0];
			assign hrem_i = hd_init[HDW-1:QS];
			assign sdq_i  = sd_init[QS-1:0];
			assign srem_i = sd_init[SDW-1:QS];
		end else begin : g_next
			assign vld_i  = vld_s2[k-1];
			assign grey_i = grey_s2[k-1];
			assign v16_i  = v16_s2[k-1];
			assign mx_i   = mx_s2[k-1];
			assign d6_i   = d6_s2[k-1];
			assign hdq_i  = hdq_s2[k-1];
			assign hrem_i = hrem_s2[k-1];
			assign sdq_i  = sdq_s2[k-1];
			assign srem_i = srem_s2[k-1];
		end

		always_comb begin
			htrial = {hrem_i, hdq_i[QS-1]};
			hge    = htrial >= {1'b0, d6_i};
			hrem_n = hge ? 11'(htrial - {1'b0, d6_i}) : htrial[10:0];
			strial = {srem_i, sdq_i[QS-1]};
			sge    = strial >= {1'b0, mx_i};
			srem_n = sge ? 8'(strial - {1'b0, mx_i}) : strial[7:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[k] <= 1'b0;
			end else begin
				vld_s2[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			grey_s2[k] <= grey_i;
			v16_s2[k]  <= v16_i;
			mx_s2[k]   <= mx_i;
			d6_s2[k]   <= d6_i;
			hrem_s2[k] <= hrem_n;
			hdq_s2[k]  <= {hdq_i[QS-2:0], hge};
			srem_s2[k] <= srem_n;
			sdq_s2[k]  <= {sdq_i[QS-2:0], sge};
		end
	end

	// ---------------------------------------------------------------- stage 3
	// Apply hue shift, wrap once, split into sector and fraction.
	logic signed [17:0] hsum;
	logic [16:0]        hwrap;
	logic [19:0]        hs6;

	always_comb begin
		hsum = $signed({2'b00, hdq_s2[L][15:0]}) + 18'(hue_shift_q);
		if (hsum > 18'sd65536) begin
			hwrap = 17'(hsum - 18'sd65536);
		end else if (hsum < 0) begin
			hwrap = 17'(hsum + 18'sd65536);
		end else begin
			hwrap = 17'(hsum);
		end
		hs6 = 20'(hwrap) * 20'd6;
	end

	logic          vld_s3, grey_s3;
	logic [23:0]   v16_s3;
	logic [QS-1:0] s16_s3;
	logic [2:0]    sec_s3;
	logic [15:0]   f_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2[L];
		end
	end

	always_ff @(posedge clk) begin
		grey_s3 <= grey_s2[L];
		v16_s3  <= v16_s2[L];
		s16_s3  <= sdq_s2[L];
		sec_s3  <= hs6[18:16];
		f_s3    <= hs6[15:0];
	end

	// ---------------------------------------------------------------- stage 4
	// Form (1 - s*k) in Q.32 for p, q and t; zero once s*k reaches 1.0.
	function automatic logic [32:0] one_minus(input logic [QS-1:0] s, input logic [16:0] k);
		logic [PW-1:0] prod;
		prod = PW'(s) * PW'(k);
		return (|prod[PW-1:32]) ? 33'd0 : 33'h1_0000_0000 - {1'b0, prod[31:0]};
	endfunction

	logic        vld_s4, grey_s4;
	logic [23:0] v16_s4;
	logic [2:0]  sec_s4;
	logic [32:0] mp_s4, mq_s4, mt_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		grey_s4 <= grey_s3;
		v16_s4  <= v16_s3;
		sec_s4  <= sec_s3;
		mp_s4   <= one_minus(s16_s3, 17'h1_0000);
		mq_s4   <= one_minus(s16_s3, {1'b0, f_s3});
		mt_s4   <= one_minus(s16_s3, 17'h1_0000 - {1'b0, f_s3});
	end

	// ---------------------------------------------------------------- stage 5
	// Split v * m into high and low partial products.
	logic        vld_s5, grey_s5;
	logic [23:0] v16_s5;
	logic [2:0]  sec_s5;
	logic [40:0] php_s5, phq_s5, pht_s5;
	logic [39:0] plp_s5, plq_s5, plt_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		grey_s5 <= grey_s4;
		v16_s5  <= v16_s4;
		sec_s5  <= sec_s4;
		php_s5  <= 41'(v16_s4) * 41'(mp_s4[32:16]);
		phq_s5  <= 41'(v16_s4) * 41'(mq_s4[32:16]);
		pht_s5  <= 41'(v16_s4) * 41'(mt_s4[32:16]);
		plp_s5  <= 40'(v16_s4) * 40'(mp_s4[15:0]);
		plq_s5  <= 40'(v16_s4) * 40'(mq_s4[15:0]);
		plt_s5  <= 40'(v16_s4) * 40'(mt_s4[15:0]);
	end

	// ---------------------------------------------------------------- stage 6
	// Sum partial products, pick channels by sector, clamp and register result.
	function automatic logic [23:0] term(input logic [40:0] hi, input logic [39:0] lo);
		logic [57:0] sum;
		sum = {1'b0, hi, 16'h0000} + 58'(lo);
		return sum[55:32];
	endfunction

	logic [23:0] tp, tq, tt, ro, go, bo;

	always_comb begin
		tp = term(php_s5, plp_s5);
		tq = term(phq_s5, plq_s5);
		tt = term(pht_s5, plt_s5);
		if (grey_s5) begin
			ro = v16_s5; go = v16_s5; bo = v16_s5;
		end else begin
			unique case (sec_s5)
				SEC_0:   begin ro = v16_s5; go = tt;     bo = tp;     end
				SEC_1:   begin ro = tq;     go = v16_s5; bo = tp;     end
				SEC_2:   begin ro = tp;     go = v16_s5; bo = tt;     end
				SEC_3:   begin ro = tp;     go = tq;     bo = v16_s5; end
				SEC_4:   begin ro = tt;     go = tp;     bo = v16_s5; end
				// Sector five and a hue of exactly one turn share this branch.
				default: begin ro = v16_s5; go = tp;     bo = tq;     end
			endcase
		end
	end

	logic    vld_s6;
	result_t res_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		res_s6.red_out   <= to_out(ro);
		res_s6.green_out <= to_out(go);
		res_s6.blue_out  <= to_out(bo);
	end

	assign result_valid = vld_s6;
	assign result       = res_s6;

endmodule
